/* rtl/pnz_pkg.sv */
// ----------------------------------------------------------------------------
// pnz_pkg
// Shared types and constants for the fractal Perlin noise block.
// ----------------------------------------------------------------------------
package pnz_pkg;

  localparam int NOISE_W = 16;
  localparam int CFG_W   = 16;

  // Configuration register indexes.
  localparam logic [0:0] REG_OCTAVE_COUNT = 1'b0;
  localparam logic [0:0] REG_PERSISTENCE  = 1'b1;

  // Input beat actions.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  localparam logic [NOISE_W-1:0] NOISE_MAX = '1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_OCT  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

endpackage

/* rtl/pnz_mul.sv */
// ----------------------------------------------------------------------------
// pnz_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pnz_mul #(
  parameter int MW = 30
) (
  input  logic                  clk,
  input  logic signed [MW-1:0]  mul_a,
  input  logic signed [MW-1:0]  mul_b,
  output logic signed [2*MW-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

endmodule

/* rtl/pnz_div.sv */
// ----------------------------------------------------------------------------
// pnz_div
// Restoring divider, one quotient bit per cycle. The numerator must be
// below the denominator, so the quotient is a pure fraction.
// ----------------------------------------------------------------------------
module pnz_div
  import pnz_pkg::*;
#(
  parameter int DW = 42
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DW-1:0]        num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic [NOISE_W-1:0]   quot
);

  localparam int CW = $clog2(NOISE_W + 1);

  logic [DW:0]   rem;
  logic [DW:0]   den_r;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem_sh;

  assign rem_sh = {rem[DW-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && (cnt == CW'(1));
      if (start) begin
        cnt   <= CW'(NOISE_W);
        rem   <= {1'b0, num};
        den_r <= {1'b0, den};
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (rem_sh >= den_r) begin
          rem  <= rem_sh - den_r;
          quot <= {quot[NOISE_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          quot <= {quot[NOISE_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

/* rtl/perlin_noise_2d_octaves.sv */
// ----------------------------------------------------------------------------
// perlin_noise_2d_octaves
// Fixed point 2D improved Perlin noise summed over fractal octaves.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): action 0 writes entry_value into the
// permutation table at entry_index and completes at once, with no result, so
// loads can follow one per cycle while idle. Action 1 evaluates noise at (x_coord,
// y_coord), signed Q16.16, and gives one noise_level beat, unsigned Q0.16.
// The table must be fully loaded before the first evaluation.
// An evaluation with N octaves does the octave work N times (ten table
// reads and eleven products per octave, all through one multiplier and one
// table read port), then a range check and the bit serial divider (start,
// sixteen quotient bits, done), and then raises out_valid. Results of zero
// or full scale skip the divider. in_stall is high from the accepted
// evaluation until its result beat has been taken; a stalled receiver
// holds the block with the result steady.
// Configuration writes (cfg_we) set octave_count and persistence; reset
// sets them to 1 and 0.5. Reset does not clear the table.
// ----------------------------------------------------------------------------
module perlin_noise_2d_octaves
  import pnz_pkg::*;
#(
  parameter int TABLE_SIZE  = 256,
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic signed [31:0]  x_coord,
  input  logic signed [31:0]  y_coord,
  input  logic [7:0]          entry_index,
  input  logic [7:0]          entry_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [NOISE_W-1:0]  noise_level,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int F   = FRAC_BITS;
  localparam int TB  = $clog2(TABLE_SIZE);
  localparam int MW  = (F + 6 > 18) ? F + 6 : 18;
  localparam int PW  = 2 * MW;
  localparam int OW  = ($clog2(MAX_OCTAVES) > 0) ? $clog2(MAX_OCTAVES) : 1;
  localparam int XW  = 32 + MAX_OCTAVES;
  localparam int OCW = $clog2(MAX_OCTAVES + 1);
  localparam int ASW = 17 + OCW;
  localparam int AW  = F + 22 + OCW;
  localparam int DW  = ASW + F + 1;
  localparam int CMW = ((AW > DW) ? AW : DW) + 1;
  localparam int SW  = 5;
  localparam logic [SW-1:0] STEP_LAST = SW'(17);
  localparam logic [16:0] AMP_ONE = 17'h10000;

  // ---- configuration ----
  logic [3:0]  octave_count;
  logic [15:0] persistence;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 4'd1;
      persistence  <= 16'h8000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OCTAVE_COUNT: octave_count <= cfg_data[3:0];
        REG_PERSISTENCE:  persistence  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---- control ----
  state_t state;
  logic   in_acc;
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  logic [SW-1:0]     step;
  logic [OW-1:0]     oct;
  logic [OCW-1:0]    oct_last;
  logic signed [31:0] x_r;
  logic signed [31:0] y_r;

  // ---- permutation table ----
  logic [7:0]    perm [TABLE_SIZE];
  logic [7:0]    perm_q;
  logic [TB-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (in_acc && action == ACT_LOAD) begin
      perm[TB'(entry_index)] <= entry_value;
    end
    perm_q <= perm[rd_addr];
  end

  // ---- cell and fraction of this octave ----
  logic [XW-1:0] xs;
  logic [XW-1:0] ys;
  logic [TB-1:0] cx;
  logic [TB-1:0] cy;
  logic [F-1:0]  fx;
  logic [F-1:0]  fy;
  logic signed [F+1:0] x0;
  logic signed [F+1:0] y0;
  logic signed [F+1:0] x1;
  logic signed [F+1:0] y1;

  assign xs = XW'(x_r) << oct;
  assign ys = XW'(y_r) << oct;
  assign cx = xs[F+TB-1:F];
  assign cy = ys[F+TB-1:F];
  assign fx = xs[F-1:0];
  assign fy = ys[F-1:0];
  assign x0 = $signed({2'b00, fx});
  assign y0 = $signed({2'b00, fy});
  assign x1 = x0 - $signed((F+2)'(1) << F);
  assign y1 = y0 - $signed((F+2)'(1) << F);

  function automatic logic signed [F+2:0] grad(input logic [3:0] h,
                                               input logic signed [F+1:0] gx,
                                               input logic signed [F+1:0] gy);
    logic signed [F+2:0] gu;
    logic signed [F+2:0] gv;
    gu = (h < 4'd8) ? (F+3)'(gx) : (F+3)'(gy);
    if (h < 4'd4) begin
      gv = (F+3)'(gy);
    end else if (h == 4'd12 || h == 4'd14) begin
      gv = (F+3)'(gx);
    end else begin
      gv = '0;
    end
    return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
  endfunction

  // ---- octave working registers ----
  logic [TB-1:0] a_r, b_r, aa_r, ab_r, ba_r, bb_r;
  logic [F-1:0]  t2x, t2y, t3x, t3y;
  logic [F:0]    fu, fv;
  logic signed [F+2:0] g00, g10, g01, g11;
  logic signed [F+3:0] lo, hi;
  logic signed [F+4:0] r1;
  logic signed [AW-1:0] acc;
  logic [ASW-1:0] amp_sum;
  logic [16:0]    amp;

  logic signed [F+4:0] px, py;
  assign px = $signed((F+5)'(t2x) * (F+5)'(6) + ((F+5)'(10) << F)
                      - (F+5)'(fx) * (F+5)'(15));
  assign py = $signed((F+5)'(t2y) * (F+5)'(6) + ((F+5)'(10) << F)
                      - (F+5)'(fy) * (F+5)'(15));

  // ---- shared multiplier ----
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_sh;
  assign prod_sh = prod >>> F;

  pnz_mul #(.MW(MW)) u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    rd_addr = cx;
    unique case (step)
      5'd0: begin
        rd_addr = cx;
        mul_a = MW'($signed({1'b0, fx}));
        mul_b = MW'($signed({1'b0, fx}));
      end
      5'd1: begin
        rd_addr = cx + 1'b1;
        mul_a = MW'($signed({1'b0, fy}));
        mul_b = MW'($signed({1'b0, fy}));
      end
      5'd2: begin
        rd_addr = a_r;
        mul_a = MW'($signed({1'b0, t2x}));
        mul_b = MW'($signed({1'b0, fx}));
      end
      5'd3: begin
        rd_addr = a_r + 1'b1;
        mul_a = MW'($signed({1'b0, t2y}));
        mul_b = MW'($signed({1'b0, fy}));
      end
      5'd4: begin
        rd_addr = b_r;
        mul_a = MW'($signed({1'b0, t3x}));
        mul_b = MW'(px);
      end
      5'd5: begin
        rd_addr = b_r + 1'b1;
        mul_a = MW'($signed({1'b0, t3y}));
        mul_b = MW'(py);
      end
      5'd6: rd_addr = aa_r;
      5'd7: rd_addr = ba_r;
      5'd8: rd_addr = ab_r;
      5'd9: begin
        rd_addr = bb_r;
        mul_a = MW'((F+4)'(g10) - (F+4)'(g00));
        mul_b = MW'($signed({1'b0, fu}));
      end
      5'd11: begin
        mul_a = MW'((F+4)'(g11) - (F+4)'(g01));
        mul_b = MW'($signed({1'b0, fu}));
      end
      5'd13: begin
        mul_a = MW'((F+5)'(hi) - (F+5)'(lo));
        mul_b = MW'($signed({1'b0, fv}));
      end
      5'd15: begin
        mul_a = MW'(r1);
        mul_b = MW'($signed({1'b0, amp}));
      end
      5'd16: begin
        mul_a = MW'($signed({1'b0, amp}));
        mul_b = MW'($signed({1'b0, persistence}));
      end
      default: ;
    endcase
  end

  // ---- divider ----
  logic                div_start;
  logic                div_done;
  logic                div_go;
  logic [NOISE_W-1:0]  quot;
  logic [DW-1:0]       den;
  logic [CMW-1:0]      acc_ext;
  logic [CMW-1:0]      den_ext;

  assign den     = DW'(amp_sum) << (F + 1);
  assign acc_ext = CMW'(acc);
  assign den_ext = CMW'(den);
  // Only a positive sum below full scale needs the divider.
  assign div_go  = (state == ST_PREP) && (acc > 0) && (acc_ext < den_ext);

  pnz_div #(.DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (DW'(acc)),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  assign out_valid = (state == ST_OUT);

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= div_go;
      unique case (state)
        ST_IDLE: begin
          if (in_acc && action == ACT_EVAL) begin
            state   <= ST_OCT;
            step    <= '0;
            oct     <= '0;
            x_r     <= x_coord;
            y_r     <= y_coord;
            acc     <= '0;
            amp_sum <= '0;
            amp     <= AMP_ONE;
            if (octave_count == 4'd0) begin
              oct_last <= '0;
            end else if (32'(octave_count) > MAX_OCTAVES) begin
              oct_last <= OCW'(MAX_OCTAVES - 1);
            end else begin
              oct_last <= OCW'(octave_count - 4'd1);
            end
          end
        end
        ST_OCT: begin
          step <= (step == STEP_LAST) ? '0 : step + 1'b1;
          unique case (step)
            5'd1: begin
              a_r <= TB'(perm_q) + cy;
              t2x <= prod[2*F-1:F];
            end
            5'd2: begin
              b_r <= TB'(perm_q) + cy;
              t2y <= prod[2*F-1:F];
            end
            5'd3: begin
              aa_r <= TB'(perm_q);
              t3x  <= prod[2*F-1:F];
            end
            5'd4: begin
              ab_r <= TB'(perm_q);
              t3y  <= prod[2*F-1:F];
            end
            5'd5: begin
              ba_r <= TB'(perm_q);
              fu   <= prod[2*F:F];
            end
            5'd6: begin
              bb_r <= TB'(perm_q);
              fv   <= prod[2*F:F];
            end
            5'd7:  g00 <= grad(perm_q[3:0], x0, y0);
            5'd8:  g10 <= grad(perm_q[3:0], x1, y0);
            5'd9:  g01 <= grad(perm_q[3:0], x0, y1);
            5'd10: begin
              g11 <= grad(perm_q[3:0], x1, y1);
              lo  <= (F+4)'(g00) + (F+4)'(prod_sh);
            end
            5'd12: hi <= (F+4)'(g01) + (F+4)'(prod_sh);
            5'd14: r1 <= (F+5)'(lo) + (F+5)'(prod_sh) + $signed((F+5)'(1) << F);
            5'd16: begin
              acc     <= acc + AW'(prod);
              amp_sum <= amp_sum + ASW'(amp);
            end
            STEP_LAST: begin
              amp <= prod[32:16];
              if (OCW'(oct) == oct_last) begin
                state <= ST_PREP;
              end else begin
                oct <= oct + 1'b1;
              end
            end
            default: ;
          endcase
        end
        ST_PREP: begin
          if (acc <= 0) begin
            noise_level <= '0;
            state       <= ST_OUT;
          end else if (acc_ext >= den_ext) begin
            noise_level <= NOISE_MAX;
            state       <= ST_OUT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            noise_level <= quot;
            state       <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
